FILE: rtl/core/gcrrw_pkg.sv
// Package for the GCR disk read/write logic: item, result and state types,
// constants and the stream packing helpers.
// No dependencies.
package gcrrw_pkg;

    localparam int unsigned ReadShiftW = 10;
    localparam int unsigned ByteW      = 8;
    localparam int unsigned InDataW    = 16;
    localparam int unsigned OutDataW   = 16;

    // Ten ones in the read shift register mark a sync
    localparam logic [ReadShiftW-1:0] SYNC_MASK = 10'h3FF;

    // Kinds of input item, carried in tuser
    typedef enum logic {
        OP_CARRY = 1'b0,
        OP_CPU   = 1'b1
    } op_t;

    // Low two bits of the clock recovery counter sequence the logic
    typedef enum logic [1:0] {
        PH_EVAL0 = 2'd0,
        PH_EVAL1 = 2'd1,
        PH_SHIFT = 2'd2,
        PH_LOAD  = 2'd3
    } crc_phase_t;

    localparam logic [2:0] BIT_COUNT_LAST = 3'd7;

    typedef struct packed {
        op_t             operation;
        logic            read_mode;
        logic            write_mode;
        logic            head_bit;
        logic            light_barrier;
        logic [ByteW-1:0] port_byte;
        logic            ca2_enable;
    } item_t;

    typedef struct packed {
        logic            head_advance;
        logic            write_strobe;
        logic            write_value;
        logic            no_sync;
        logic            byte_ready_level;
        logic            byte_ready_edge;
        logic [ByteW-1:0] read_byte;
    } result_t;

    typedef struct packed {
        logic [3:0]            clock_recovery_count;
        logic [1:0]            carry_phase;
        logic [ReadShiftW-1:0] read_shift;
        logic [ByteW-1:0]      write_shift;
        logic [2:0]            bit_counter;
        logic                  ready_line;
    } state_t;

    // Unpack one input transaction
    function automatic item_t unpack_item(input logic [InDataW-1:0] data, input logic kind);
        item_t it;
        it.operation     = op_t'(kind);
        it.read_mode     = data[0];
        it.write_mode    = data[1];
        it.head_bit      = data[2];
        it.light_barrier = data[3];
        it.port_byte     = data[11:4];
        it.ca2_enable    = data[12];
        return it;
    endfunction

    // Pack one result transaction
    function automatic logic [OutDataW-1:0] pack_result(input result_t r);
        logic [OutDataW-1:0] d;
        d        = '0;
        d[0]     = r.head_advance;
        d[1]     = r.write_strobe;
        d[2]     = r.write_value;
        d[3]     = r.no_sync;
        d[4]     = r.byte_ready_level;
        d[5]     = r.byte_ready_edge;
        d[13:6]  = r.read_byte;
        return d;
    endfunction

endpackage

FILE: rtl/core/gcrrw_step.sv
// One step of the read/write logic: next state and result for one item.
// Purely combinational; depends on gcrrw_pkg.
module gcrrw_step (
    input  gcrrw_pkg::state_t  state,
    input  gcrrw_pkg::item_t   item,
    output gcrrw_pkg::state_t  state_next,
    output gcrrw_pkg::result_t result
);
    import gcrrw_pkg::*;

    logic [3:0]  crc_inc;
    logic [1:0]  phase_inc;
    logic [3:0]  crc_new;
    logic        nosync;
    logic [2:0]  bc_sync;
    logic        ready_cpu;
    logic        ready_carry_eval;
    state_t      ns;
    result_t     res;

    // Counters and sync detection on the current state
    always_comb
    begin
        crc_inc   = state.clock_recovery_count + 4'd1;
        phase_inc = state.carry_phase + 2'd1;
        if (phase_inc == 2'd0 && item.read_mode && item.head_bit)
            crc_new = 4'd0;
        else
            crc_new = crc_inc;
        nosync  = (state.read_shift != SYNC_MASK) || item.write_mode;
        bc_sync = nosync ? state.bit_counter : 3'd0;
        // Byte ready goes low only with enable, counter bit 1 clear and a full byte
        ready_cpu = !(item.ca2_enable && !state.clock_recovery_count[1]
                      && state.bit_counter == BIT_COUNT_LAST);
        ready_carry_eval = !(item.ca2_enable && !crc_new[1] && bc_sync == BIT_COUNT_LAST);
    end

    // Next state and result
    always_comb
    begin
        ns  = state;
        res = '0;
        res.no_sync = nosync;
        unique case (item.operation)
            OP_CPU:
            begin
                ns.ready_line = ready_cpu;
            end
            OP_CARRY:
            begin
                ns.clock_recovery_count = crc_new;
                ns.carry_phase          = phase_inc;
                ns.bit_counter          = bc_sync;
                res.head_advance        = (phase_inc == 2'd0);
                unique case (crc_phase_t'(crc_new[1:0]))
                    PH_EVAL0, PH_EVAL1:
                    begin
                        ns.ready_line = ready_carry_eval;
                    end
                    PH_SHIFT:
                    begin
                        ns.ready_line  = 1'b1;
                        ns.bit_counter = nosync ? bc_sync + 3'd1 : 3'd0;
                        if (item.write_mode && !item.light_barrier)
                        begin
                            res.write_strobe = 1'b1;
                            res.write_value  = state.write_shift[ByteW-1];
                        end
                        ns.write_shift = {state.write_shift[ByteW-2:0], 1'b0};
                        ns.read_shift  = {state.read_shift[ReadShiftW-2:0],
                                          (crc_new[3:2] == 2'b00)};
                    end
                    PH_LOAD:
                    begin
                        if (bc_sync == BIT_COUNT_LAST)
                            ns.write_shift = item.port_byte;
                    end
                    default:
                    begin
                        ns.ready_line = ready_carry_eval;
                    end
                endcase
            end
            default:
            begin
                ns.ready_line = ready_cpu;
            end
        endcase
        res.byte_ready_level = ns.ready_line;
        res.byte_ready_edge  = ns.ready_line ^ state.ready_line;
        res.read_byte        = ns.read_shift[ByteW-1:0];
    end

    assign state_next = ns;
    assign result     = res;

endmodule

FILE: rtl/core/gcr_disk_read_write_logic.sv
// Top level of the GCR disk read/write logic: input register, state
// register and result register around the step logic.
// Depends on gcrrw_pkg and gcrrw_step.
//
// Usage:
//   Slave stream s_axis_* carries items: tuser is the kind (0 = carry pulse,
//   1 = CPU cycle that only re-evaluates byte ready); tdata the item fields.
//   Master stream m_axis_* carries one result transaction per item.
//   Each item waits in the input register, then its result is loaded into
//   the result register. Throughput: one item per cycle while the receiver
//   does not stall; the step is a few gates between the input register and
//   the result register, and the drive state is updated in the same cycle
//   the result is registered.
//   Reset (rst_n low, asynchronous) clears the clock recovery counter,
//   carry phase, both shift registers, bit counter, byte-ready line and
//   both valid flags.
//   When the receiver stalls the result register holds its transaction;
//   the input register still takes one more item, then tready drops until
//   the result is taken.
module gcr_disk_read_write_logic (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] read_mode, [1] write_mode, [2] head_bit, [3] light_barrier,
    // [11:4] port_byte, [12] ca2_enable, [15:13] zero
    input  logic [gcrrw_pkg::InDataW-1:0] s_axis_tdata,
    // [0] operation
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] head_advance, [1] write_strobe, [2] write_value, [3] no_sync,
    // [4] byte_ready_level, [5] byte_ready_edge, [13:6] read_byte, [15:14] zero
    output logic [gcrrw_pkg::OutDataW-1:0] m_axis_tdata
);
    import gcrrw_pkg::*;

    logic                in_valid_reg;
    logic                in_valid_next;
    item_t               item_reg;
    state_t              state_reg;
    state_t              state_next;
    result_t             step_result;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [OutDataW-1:0] out_data_reg;
    logic                in_take;
    logic                fire;

    // Handshake control
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // Step logic
    gcrrw_step u_step (
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // Control and drive state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
                state_reg <= state_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            item_reg <= unpack_item(s_axis_tdata, s_axis_tuser);
        if (fire)
            out_data_reg <= pack_result(step_result);
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
